// ----- rtl/pida_pkg.sv -----
// Package: shared types and codes for the positional insert/delete array.
package pida_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int LIST_MAX  = 16;

  localparam logic [1:0] CMD_LIST = 2'd0;
  localparam logic [1:0] CMD_INS  = 2'd1;
  localparam logic [1:0] CMD_DEL  = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_BADPOS = 2'd3;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [4:0]         position;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [3:0]         entry_index;
    logic signed [31:0] entry_value;
    logic [4:0]         stored_count;
    logic               last;
  } out_t;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_SH_RD   = 6'b000010,
    S_SH_WR   = 6'b000100,
    S_LS_RD   = 6'b001000,
    S_LS_WAIT = 6'b010000,
    S_EMIT    = 6'b100000
  } state_t;

endpackage

// ----- rtl/positional_insert_delete_array.sv -----
// Top level: ordered array with positional insert, delete and listing.
//
// Channels: in_valid/in_ready/in_data carry one command transaction (list,
// insert, delete); out_valid/out_ready/out_data carry result transactions.
// Insert, delete and rejected commands give one result with last set; a
// listing gives one result per stored entry (at most 16), last on the final.
// Entries sit in a single-port-write, registered-read memory; one shared
// index register walks it under a small sequencer. Insert and delete shift
// the entries from the position to the end one at a time, each a read then
// a write; a listing reads each entry, then emits it as a result.
// The block takes one command at a time; in_ready is high only when idle.
// A stalled receiver holds the output register and the sequencer waits.
// Synchronous active-low reset clears the count and control state; the
// memory contents are not cleared.
module positional_insert_delete_array #(
  parameter int DEPTH = pida_pkg::DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  pida_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output pida_pkg::out_t out_data
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > 5) ? CW : 5;

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_r;

  pida_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [AW-1:0]    idx_r, idx_nxt;
  logic [AW-1:0]    pos_r, pos_nxt;
  logic [31:0]      val_r, val_nxt;
  logic             ins_r, ins_nxt;
  logic             list_r, list_nxt;
  pida_pkg::out_t   pend_r, pend_nxt;
  pida_pkg::out_t   out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic             we;
  logic [AW-1:0]    wa;
  logic [31:0]      wd;
  logic [AW-1:0]    ra;

  logic [CMPW-1:0]  cnt_w, pos_w, idx1_w, lim_w;
  logic             load_out;

  assign cnt_w  = CMPW'(count_r);
  assign pos_w  = CMPW'(in_data.position);
  assign idx1_w = CMPW'(idx_r) + CMPW'(1);
  assign lim_w  = (cnt_w > CMPW'(pida_pkg::LIST_MAX)) ? CMPW'(pida_pkg::LIST_MAX) : cnt_w;

  assign in_ready  = (state_r == pida_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign load_out  = (state_r == pida_pkg::S_EMIT) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata_r <= mem[ra];
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    val_nxt       = val_r;
    ins_nxt       = ins_r;
    list_nxt      = list_r;
    pend_nxt      = pend_r;
    we            = 1'b0;
    wa            = idx_r;
    wd            = rdata_r;
    ra            = idx_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      pida_pkg::S_IDLE: begin
        if (in_valid) begin
          pend_nxt              = '0;
          pend_nxt.stored_count = 5'(count_r);
          pend_nxt.last         = 1'b1;
          list_nxt              = 1'b0;
          state_nxt             = pida_pkg::S_EMIT;
          priority if (in_data.cmd == pida_pkg::CMD_LIST) begin
            if (count_r == '0) begin
              pend_nxt.status = pida_pkg::ST_EMPTY;
            end else begin
              list_nxt  = 1'b1;
              idx_nxt   = '0;
              state_nxt = pida_pkg::S_LS_RD;
            end
          end else if (in_data.cmd == pida_pkg::CMD_INS) begin
            if (cnt_w >= CMPW'(DEPTH)) begin
              pend_nxt.status = pida_pkg::ST_FULL;
            end else if (pos_w > cnt_w) begin
              pend_nxt.status = pida_pkg::ST_BADPOS;
            end else begin
              ins_nxt   = 1'b1;
              idx_nxt   = AW'(count_r);
              pos_nxt   = AW'(in_data.position);
              val_nxt   = in_data.value;
              state_nxt = pida_pkg::S_SH_RD;
            end
          end else if (in_data.cmd == pida_pkg::CMD_DEL) begin
            if (count_r == '0) begin
              pend_nxt.status = pida_pkg::ST_EMPTY;
            end else if (pos_w >= cnt_w) begin
              pend_nxt.status = pida_pkg::ST_BADPOS;
            end else begin
              ins_nxt   = 1'b0;
              idx_nxt   = AW'(in_data.position);
              state_nxt = pida_pkg::S_SH_RD;
            end
          end else begin
            pend_nxt.status = pida_pkg::ST_BADPOS;
          end
        end
      end
      pida_pkg::S_SH_RD: begin
        if (ins_r) begin
          if (idx_r == pos_r) begin
            we                    = 1'b1;
            wd                    = val_r;
            count_nxt             = count_r + CW'(1);
            pend_nxt              = '0;
            pend_nxt.stored_count = 5'(count_nxt);
            pend_nxt.last         = 1'b1;
            state_nxt             = pida_pkg::S_EMIT;
          end else begin
            ra        = idx_r - AW'(1);
            state_nxt = pida_pkg::S_SH_WR;
          end
        end else begin
          if (idx1_w >= cnt_w) begin
            count_nxt             = count_r - CW'(1);
            pend_nxt              = '0;
            pend_nxt.stored_count = 5'(count_nxt);
            pend_nxt.last         = 1'b1;
            state_nxt             = pida_pkg::S_EMIT;
          end else begin
            ra        = AW'(idx1_w);
            state_nxt = pida_pkg::S_SH_WR;
          end
        end
      end
      pida_pkg::S_SH_WR: begin
        we        = 1'b1;
        idx_nxt   = ins_r ? (idx_r - AW'(1)) : AW'(idx1_w);
        state_nxt = pida_pkg::S_SH_RD;
      end
      pida_pkg::S_LS_RD: begin
        state_nxt = pida_pkg::S_LS_WAIT;
      end
      pida_pkg::S_LS_WAIT: begin
        pend_nxt.status       = pida_pkg::ST_OK;
        pend_nxt.entry_index  = 4'(idx_r);
        pend_nxt.entry_value  = rdata_r;
        pend_nxt.stored_count = 5'(count_r);
        pend_nxt.last         = (idx1_w == lim_w);
        state_nxt             = pida_pkg::S_EMIT;
      end
      pida_pkg::S_EMIT: begin
        if (load_out) begin
          out_nxt       = pend_r;
          out_valid_nxt = 1'b1;
          if (list_r && !pend_r.last) begin
            idx_nxt   = AW'(idx1_w);
            state_nxt = pida_pkg::S_LS_RD;
          end else begin
            state_nxt = pida_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = pida_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pida_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      ins_r       <= 1'b0;
      list_r      <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      ins_r       <= ins_nxt;
      list_r      <= list_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r  <= pos_nxt;
    val_r  <= val_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMPW'(count_r) <= CMPW'(DEPTH))
    else $error("count exceeds depth");

  a_full_ins_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.cmd == pida_pkg::CMD_INS &&
     CMPW'(count_r) == CMPW'(DEPTH)) |=> (count_r == $past(count_r)))
    else $error("insert into full array changed count");

  a_notlast_is_list: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.last) |-> (out_r.status == pida_pkg::ST_OK && list_r))
    else $error("non-final result outside a listing");
`endif

endmodule
